[rtl/core/bounded_ordered_list_engine_assert.svh]
// Assertion macros for the bounded ordered list engine
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BOLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bole assertion failed");

// next-cycle implication, checked outside reset
`define BOLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bole assertion failed");

`endif

[rtl/core/bole_pkg.sv]
// Shared types, field widths and command codes of the bounded ordered list engine
`default_nettype none
package bole_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int REQ_W  = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int REM_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND     = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PREPEND    = 4'd1;
  localparam logic [REQ_W-1:0] REQ_DROP_LAST  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DROP_FIRST = 4'd3;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_READ       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_WRITE      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0]  read_data;
    logic [CNT_W-1:0]  count;
    logic [REM_W-1:0]  removed;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine: sequencer plus result register
`default_nettype none
// Keeps an ordered list of up to DEPTH words in a single-port-write,
// registered-read store and runs one command per input beat. Commands
// that move entries walk the store one entry per cycle. in_ready is low
// while a command runs; the result register lets the next command start
// while the previous result waits on out_ready. No clearing pass runs
// after reset.
module bounded_ordered_list_engine #(
  parameter int DEPTH      = bole_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bole_pkg::DATA_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bole_pkg::REQ_W-1:0]        req_type,
  input  logic signed [bole_pkg::VAL_W-1:0] value,
  input  logic [bole_pkg::POS_W-1:0]        position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bole_pkg::VAL_W-1:0] read_data,
  output logic [bole_pkg::CNT_W-1:0]        count,
  output logic [bole_pkg::REM_W-1:0]        removed,
  output logic [bole_pkg::STAT_W-1:0]       status
);
  import bole_pkg::*;

  logic slot_free;
  logic emit;
  res_t res;
  res_t res_q;

  assign slot_free = !out_valid || out_ready;

  bole_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .position  (position),
    .slot_free (slot_free),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign read_data = res_q.read_data;
  assign count     = res_q.count;
  assign removed   = res_q.removed;
  assign status    = res_q.status;

endmodule
`default_nettype wire

[rtl/core/bole_ram.sv]
// Entry store: one write port, one registered read port
`default_nettype none
module bole_ram #(
  parameter int DEPTH      = bole_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bole_pkg::DATA_W_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/bole_seq.sv]
// Command sequencer: decodes a beat, walks the entry store one entry per cycle
`default_nettype none
module bole_seq #(
  parameter int DEPTH      = bole_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bole_pkg::DATA_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bole_pkg::REQ_W-1:0]       req_type,
  input  logic signed [bole_pkg::VAL_W-1:0] value,
  input  logic [bole_pkg::POS_W-1:0]       position,
  input  logic                             slot_free,
  output logic                             emit,
  output bole_pkg::res_t                   res
);
  import bole_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_TAIL, OP_SHUP, OP_DEC, OP_SHDN, OP_REM, OP_RD, OP_WR, OP_CLR
  } op_t;

  state_t                state;
  op_t                   op;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         dst;
  logic [CW-1:0]         rem_cnt;
  logic [AW-1:0]         src;
  logic [AW-1:0]         last;
  logic [AW-1:0]         wr_addr;
  logic                  up;
  logic                  pend;
  logic [STAT_W-1:0]     status_q;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] w_in;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic                  full;
  logic                  empty;
  logic                  pos_oob;
  logic                  neq;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [DATA_WIDTH-1:0] rdata;

  bole_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (src),
    .rdata (rdata)
  );

  assign w_in    = DATA_WIDTH'(value);
  assign pos_x   = PW'(position);
  assign cnt_x   = PW'(cnt);
  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign pos_oob = (pos_x >= cnt_x);
  assign cnt_m1  = cnt - CW'(1);
  assign neq     = (rdata != word);

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_FIN) && slot_free;
  assign re       = (state == S_WALK);

  // store write: moves during the walk, the final word at finish
  always_comb begin
    we    = 1'b0;
    waddr = dst[AW-1:0];
    wdata = rdata;
    priority if (pend && (op == OP_SHUP || op == OP_SHDN || (op == OP_REM && neq))) begin
      we = 1'b1;
    end else if (emit && (op == OP_TAIL || op == OP_SHUP || op == OP_WR)) begin
      we    = 1'b1;
      waddr = wr_addr;
      wdata = word;
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    unique case (op)
      OP_TAIL, OP_SHUP: cnt_next = cnt + CW'(1);
      OP_DEC, OP_SHDN:  cnt_next = cnt_m1;
      OP_REM:           cnt_next = dst;
      OP_CLR:           cnt_next = '0;
      default:          cnt_next = cnt;
    endcase
  end

  assign res.read_data = VAL_W'(rd_word);
  assign res.count     = CNT_W'(cnt_next);
  assign res.removed   = REM_W'(rem_cnt);
  assign res.status    = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            word     <= w_in;
            status_q <= ST_OK;
            rem_cnt  <= '0;
            rd_word  <= '0;
            dst      <= '0;
            up       <= 1'b1;
            src      <= '0;
            last     <= AW'(cnt_m1);
            wr_addr  <= AW'(position);
            op       <= OP_NONE;
            state    <= S_FIN;
            unique case (req_type)
              REQ_APPEND, REQ_PREPEND, REQ_INSERT: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else if (req_type == REQ_APPEND || empty ||
                             (req_type == REQ_INSERT && pos_oob)) begin
                  op      <= OP_TAIL;
                  wr_addr <= AW'(cnt);
                end else begin
                  // shift the tail up by one, last entry first
                  op    <= OP_SHUP;
                  src   <= AW'(cnt_m1);
                  up    <= 1'b0;
                  dst   <= cnt;
                  state <= S_WALK;
                  if (req_type == REQ_PREPEND) begin
                    last    <= '0;
                    wr_addr <= '0;
                  end else begin
                    last <= AW'(position);
                  end
                end
              end
              REQ_DROP_LAST: begin
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  op <= OP_DEC;
                end
              end
              REQ_DROP_FIRST: begin
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else if (cnt == CW'(1)) begin
                  op <= OP_DEC;
                end else begin
                  op    <= OP_SHDN;
                  src   <= AW'(1);
                  state <= S_WALK;
                end
              end
              REQ_REMOVE: begin
                if (!empty) begin
                  op    <= OP_REM;
                  state <= S_WALK;
                end
              end
              REQ_READ: begin
                if (pos_oob) begin
                  status_q <= ST_RANGE;
                end else begin
                  op    <= OP_RD;
                  src   <= AW'(position);
                  last  <= AW'(position);
                  state <= S_WALK;
                end
              end
              REQ_WRITE: begin
                if (pos_oob) begin
                  status_q <= ST_RANGE;
                end else begin
                  op <= OP_WR;
                end
              end
              REQ_CLEAR: begin
                op <= OP_CLR;
              end
              default: begin
                op <= OP_NONE;
              end
            endcase
          end
        end
        S_WALK: begin
          pend <= 1'b1;
          if (src == last) begin
            state <= S_DRAIN;
          end else begin
            src <= up ? src + AW'(1) : src - AW'(1);
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            cnt   <= cnt_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // read data of the previous cycle's walk step lands here
      if (pend) begin
        unique case (op)
          OP_SHUP: dst <= dst - CW'(1);
          OP_SHDN: dst <= dst + CW'(1);
          OP_REM: begin
            if (neq) begin
              dst <= dst + CW'(1);
            end else begin
              rem_cnt <= rem_cnt + CW'(1);
            end
          end
          OP_RD:   rd_word <= rdata;
          default: ;
        endcase
      end
    end
  end

`include "bounded_ordered_list_engine_assert.svh"

  `BOLE_ASSERT_NOW(a_drain_has_data, state == S_DRAIN, pend)
  `BOLE_ASSERT_NOW(a_idle_no_pend, state == S_IDLE, !pend)
  `BOLE_ASSERT_NOW(a_walk_no_overlap, state == S_WALK && we, waddr != src)
  `BOLE_ASSERT_NEXT(a_fin_returns, state == S_FIN && slot_free, state == S_IDLE)
  `BOLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CW'(DEPTH))

endmodule
`default_nettype wire

[tb/bounded_ordered_list_engine_tb.sv]
// Self-checking testbench for the bounded ordered list engine command set
`default_nettype none
module bounded_ordered_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bole_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int MAX_SHOWN  = 10;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         req_type  = '0;
  logic signed [VAL_W-1:0]  value     = '0;
  logic [POS_W-1:0]         position  = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [VAL_W-1:0]  read_data;
  logic [CNT_W-1:0]         count;
  logic [REM_W-1:0]         removed;
  logic [STAT_W-1:0]        status;

  // predicted list contents, updated as each command beat is accepted
  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int unsigned             list_len = 0;
  res_t                    pending_results [$];
  int unsigned             bad_results = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  bounded_ordered_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .count     (count),
    .removed   (removed),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic res_t apply_list_cmd(logic [REQ_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                                          logic [POS_W-1:0] pos);
    res_t        r;
    int unsigned i;
    int unsigned ins_at;
    int unsigned keep;
    int unsigned hits;
    r = '0;
    hits = 0;
    case (cmd)
      REQ_APPEND, REQ_PREPEND, REQ_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == REQ_APPEND || (cmd == REQ_INSERT && pos >= list_len)) ins_at = list_len;
          else if (cmd == REQ_PREPEND) ins_at = 0;
          else ins_at = pos;
          for (i = list_len; i > ins_at; i--) list_mem[i] = list_mem[i-1];
          list_mem[ins_at] = val;
          list_len++;
        end
      end
      REQ_DROP_LAST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      REQ_DROP_FIRST: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      REQ_REMOVE: begin
        keep = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] != val) begin
            list_mem[keep] = list_mem[i];
            keep++;
          end else begin
            hits++;
          end
        end
        list_len = keep;
      end
      REQ_READ: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.read_data = list_mem[pos];
      end
      REQ_WRITE: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else list_mem[pos] = val;
      end
      REQ_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count   = CNT_W'(list_len);
    r.removed = REM_W'(hits);
    return r;
  endfunction

  // one command beat; valid stays up between back-to-back beats
  task automatic send_cmd(logic [REQ_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                          logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= cmd;
    value    <= val;
    position <= pos;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.insert(pending_results.size(), apply_list_cmd(cmd, val, pos));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.read_data = read_data;
      got.count     = count;
      got.removed   = removed;
      got.status    = status;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_SHOWN)
          $display("%0t unexpected result beat: data=%h count=%0d removed=%0d status=%0d",
                   $realtime, got.read_data, got.count, got.removed, got.status);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.read_data !== want.read_data || got.count !== want.count ||
            got.removed !== want.removed || got.status !== want.status) begin
          bad_results++;
          // fields shown as data/count/removed/status
          if (bad_results <= MAX_SHOWN)
            $display("%0t mismatch: got %h/%0d/%0d/%0d want %h/%0d/%0d/%0d",
                     $realtime, got.read_data, got.count, got.removed, got.status,
                     want.read_data, want.count, want.removed, want.status);
        end
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom;
      // narrow pool so remove-value finds matches
      default: return $signed(VAL_W'($urandom_range(7))) - 32'sd2;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return POS_W'($urandom_range(31));
    else if (roll < 30) return POS_W'(list_len);
    else return POS_W'($urandom_range(list_len));
  endfunction

  task automatic test_empty_list();
    send_cmd(REQ_DROP_LAST, 32'sd0, 5'd0);
    send_cmd(REQ_DROP_FIRST, 32'sd0, 5'd0);
    send_cmd(REQ_READ, 32'sd0, 5'd0);
    send_cmd(REQ_WRITE, 32'sd3, 5'd0);
    send_cmd(REQ_REMOVE, 32'sd7, 5'd0);
    wait_drained();
  endtask

  task automatic test_insert_positions();
    send_cmd(REQ_APPEND, 32'sh7FFF_FFFF, 5'd0);
    send_cmd(REQ_PREPEND, 32'sh8000_0000, 5'd9);
    send_cmd(REQ_INSERT, -32'sd1, 5'd31);
    send_cmd(REQ_INSERT, 32'sd0, 5'd0);
    send_cmd(REQ_INSERT, 32'sd5, 5'd2);
  endtask

  task automatic test_index_access();
    send_cmd(REQ_READ, 32'sd0, 5'd2);
    send_cmd(REQ_WRITE, 32'sh5555_AAAA, 5'd4);
    send_cmd(REQ_READ, 32'sd0, 5'd4);
    send_cmd(REQ_READ, 32'sd0, 5'(list_len));
    send_cmd(REQ_WRITE, 32'sd1, 5'd16);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_DEPTH)
      send_cmd(list_len[0] ? REQ_PREPEND : REQ_APPEND, -32'sd1, 5'd0);
    send_cmd(REQ_APPEND, 32'sd9, 5'd0);
    send_cmd(REQ_PREPEND, 32'sd9, 5'd0);
    send_cmd(REQ_INSERT, 32'sd9, 5'd8);
  endtask

  task automatic test_remove_and_clear();
    send_cmd(REQ_REMOVE, -32'sd1, 5'd0);
    send_cmd(REQ_DROP_FIRST, 32'sd0, 5'd0);
    send_cmd(REQ_DROP_LAST, 32'sd0, 5'd0);
    send_cmd(REQ_CLEAR, 32'sd0, 5'd0);
  endtask

  task automatic test_unknown_codes();
    send_cmd(4'd9, 32'sd1, 5'd1);
    send_cmd(4'd15, -32'sd1, 5'd31);
    wait_drained();
  endtask

  // grow/shrink bias flips at full and empty so both extremes get visited often
  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned      k;
    int unsigned      roll;
    int unsigned      grow_pct;
    logic [REQ_W-1:0] cmd;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    grow_pct = 60;
    for (k = 0; k < n_items; k++) begin
      if (list_len >= LIST_DEPTH) grow_pct = 25;
      else if (list_len == 0) grow_pct = 75;
      roll = $urandom_range(99);
      if (roll < 3) begin
        cmd = REQ_W'($urandom_range(9, 15));
      end else if (roll < 5) begin
        cmd = REQ_CLEAR;
      end else if ($urandom_range(99) < grow_pct) begin
        case ($urandom_range(2))
          0:       cmd = REQ_APPEND;
          1:       cmd = REQ_PREPEND;
          default: cmd = REQ_INSERT;
        endcase
      end else begin
        case ($urandom_range(4))
          0:       cmd = REQ_DROP_LAST;
          1:       cmd = REQ_DROP_FIRST;
          2:       cmd = REQ_REMOVE;
          3:       cmd = REQ_READ;
          default: cmd = REQ_WRITE;
        endcase
      end
      send_cmd(cmd, pick_value(), pick_position());
      if ($urandom_range(199) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_insert_positions();
    test_index_access();
    test_full_list();
    test_remove_and_clear();
    test_unknown_codes();
    test_random_traffic(340, 20, 80);
    test_random_traffic(340, 80, 20);
    test_random_traffic(340, 0, 0);

    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) bad_results++;
    if (bad_results == 0) begin
      $display("bounded_ordered_list_engine verification clean");
    end else begin
      $display("bounded_ordered_list_engine verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("bounded_ordered_list_engine verification failed");
    $finish;
  end

endmodule
`default_nettype wire
